### rtl/psev_pkg.sv
// Package of shared constants, types and the symbol decoder for the postfix stack evaluator.
`default_nettype none
package psev_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DSTEP_W     = $clog2(DATA_WIDTH + 1);

  localparam logic [7:0] SYM_DIGIT_LO = 8'd48;
  localparam logic [7:0] SYM_DIGIT_HI = 8'd57;
  localparam logic [7:0] SYM_MUL      = 8'd90;
  localparam logic [7:0] SYM_ADD      = 8'd91;
  localparam logic [7:0] SYM_SUB      = 8'd93;
  localparam logic [7:0] SYM_DIV      = 8'd95;
  localparam logic [7:0] SYM_END      = 8'd111;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV,
    OP_END,
    OP_BAD
  } psev_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_POP_B,
    S_POP_A,
    S_CAP_A,
    S_EXEC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_END_POP,
    S_END_OUT
  } psev_state_t;

  typedef struct packed {
    logic bad_op;
    logic div_zero;
    logic overflow;
    logic underflow;
  } psev_flags_t;

  typedef struct packed {
    logic accept;
    logic load_digit;
    logic pop;
    logic cap_b;
    logic cap_a;
    logic exec;
    logic div_start;
    logic div_zero;
    logic div_take;
    logic push;
    logic finish;
  } psev_cmd_t;

  typedef struct packed {
    psev_op_t in_op;
    psev_op_t op;
    logic     b_zero;
    logic     div_done;
    logic     out_hold;
  } psev_sts_t;

  function automatic psev_op_t decode_symbol(logic [7:0] s);
    psev_op_t o;
    if (s >= SYM_DIGIT_LO && s <= SYM_DIGIT_HI) begin
      o = OP_DIGIT;
    end else begin
      unique case (s)
        SYM_MUL: o = OP_MUL;
        SYM_ADD: o = OP_ADD;
        SYM_SUB: o = OP_SUB;
        SYM_DIV: o = OP_DIV;
        SYM_END: o = OP_END;
        default: o = OP_BAD;
      endcase
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### rtl/psev_div.sv
// Radix-2 restoring signed divider that produces one quotient bit per cycle.
`default_nettype none
module psev_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [psev_pkg::DATA_WIDTH-1:0] dividend,
  input  wire logic [psev_pkg::DATA_WIDTH-1:0] divisor,
  output logic                                 done,
  output logic      [psev_pkg::DATA_WIDTH-1:0] quotient
);

  localparam int DW = psev_pkg::DATA_WIDTH;

  logic [DW-1:0]                  quo;
  logic [DW-1:0]                  dvs;
  logic [DW:0]                    rem;
  logic [psev_pkg::DSTEP_W-1:0]   steps;
  logic                           busy;
  logic                           neg;
  logic [DW:0]                    shifted;
  logic                           fits;

  assign shifted  = {rem[DW-1:0], quo[DW-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = neg ? (~quo + DW'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= psev_pkg::DSTEP_W'(DW);
      end else if (busy) begin
        steps <= steps - psev_pkg::DSTEP_W'(1);
        if (steps == psev_pkg::DSTEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
      dvs <= divisor[DW-1] ? (~divisor + DW'(1)) : divisor;
      rem <= '0;
      neg <= dividend[DW-1] ^ divisor[DW-1];
    end else if (busy) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
    end
  end

endmodule
`default_nettype wire

### rtl/psev_datapath.sv
// Datapath with the operand stack memory, operand registers, arithmetic and the result register.
`default_nettype none
module psev_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire psev_pkg::psev_cmd_t             cmd,
  output psev_pkg::psev_sts_t                  sts,
  input  wire logic [7:0]                      symbol,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [psev_pkg::DATA_WIDTH-1:0] value,
  output logic                                 underflow_seen,
  output logic                                 overflow_seen,
  output logic                                 div_zero_seen,
  output logic                                 bad_operator_seen
);

  localparam int DW = psev_pkg::DATA_WIDTH;

  logic [DW-1:0]               mem [psev_pkg::STACK_DEPTH];
  logic [DW-1:0]               rdata;
  logic [psev_pkg::CNT_W-1:0]  cnt;
  logic [psev_pkg::CNT_W-1:0]  cnt_dec;
  logic                        hit;
  logic                        empty;
  logic                        full;
  psev_pkg::psev_flags_t       flags;
  psev_pkg::psev_op_t          op;
  logic [DW-1:0]               opa;
  logic [DW-1:0]               opb;
  logic [DW-1:0]               res;
  logic [DW-1:0]               popped;
  logic [7:0]                  sym_diff;
  logic                        div_done;
  logic [DW-1:0]               div_q;

  assign cnt_dec  = cnt - psev_pkg::CNT_W'(1);
  assign empty    = cnt == '0;
  assign full     = cnt == psev_pkg::CNT_W'(psev_pkg::STACK_DEPTH);
  assign popped   = hit ? rdata : '0;
  assign sym_diff = symbol - psev_pkg::SYM_DIGIT_LO;

  assign sts.in_op    = psev_pkg::decode_symbol(symbol);
  assign sts.op       = op;
  assign sts.b_zero   = opb == '0;
  assign sts.div_done = div_done;
  assign sts.out_hold = out_valid & ~out_ready;

  psev_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.pop && !empty) begin
      rdata <= mem[cnt_dec[psev_pkg::PTR_W-1:0]];
    end
    if (cmd.push && !full) begin
      mem[cnt[psev_pkg::PTR_W-1:0]] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      flags     <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.pop) begin
        hit <= !empty;
        if (empty) begin
          flags.underflow <= 1'b1;
        end else begin
          cnt <= cnt_dec;
        end
      end
      if (cmd.push) begin
        if (full) begin
          flags.overflow <= 1'b1;
        end else begin
          cnt <= cnt + psev_pkg::CNT_W'(1);
        end
      end
      if (cmd.div_zero) begin
        flags.div_zero <= 1'b1;
      end
      if (cmd.exec && op == psev_pkg::OP_BAD) begin
        flags.bad_op <= 1'b1;
      end
      if (cmd.finish) begin
        cnt   <= '0;
        flags <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= sts.in_op;
    end
    if (cmd.cap_b) begin
      opb <= popped;
    end
    if (cmd.cap_a) begin
      opa <= popped;
    end
    if (cmd.load_digit) begin
      res <= DW'(sym_diff[3:0]);
    end else if (cmd.exec) begin
      case (op)
        psev_pkg::OP_MUL: res <= opa * opb;
        psev_pkg::OP_ADD: res <= opa + opb;
        psev_pkg::OP_SUB: res <= opa - opb;
        default:          res <= '0;
      endcase
    end else if (cmd.div_zero) begin
      res <= '0;
    end else if (cmd.div_take) begin
      res <= div_q;
    end
    if (cmd.finish) begin
      value             <= popped;
      underflow_seen    <= flags.underflow;
      overflow_seen     <= flags.overflow;
      div_zero_seen     <= flags.div_zero;
      bad_operator_seen <= flags.bad_op;
    end
  end

endmodule
`default_nettype wire

### rtl/psev_ctrl.sv
// Controller state machine that sequences pops, arithmetic, pushes and result delivery.
`default_nettype none
module psev_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire psev_pkg::psev_sts_t sts,
  output psev_pkg::psev_cmd_t      cmd
);

  psev_pkg::psev_state_t state;
  psev_pkg::psev_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psev_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psev_pkg::S_IDLE: begin
        if (in_valid) begin
          case (sts.in_op)
            psev_pkg::OP_DIGIT: state_next = psev_pkg::S_PUSH;
            psev_pkg::OP_END:   state_next = psev_pkg::S_END_POP;
            default:            state_next = psev_pkg::S_POP_B;
          endcase
        end
      end
      psev_pkg::S_PUSH:    state_next = psev_pkg::S_IDLE;
      psev_pkg::S_POP_B:   state_next = psev_pkg::S_POP_A;
      psev_pkg::S_POP_A:   state_next = psev_pkg::S_CAP_A;
      psev_pkg::S_CAP_A: begin
        state_next = (sts.op == psev_pkg::OP_DIV) ? psev_pkg::S_DIV_GO : psev_pkg::S_EXEC;
      end
      psev_pkg::S_EXEC:    state_next = psev_pkg::S_PUSH;
      psev_pkg::S_DIV_GO: begin
        state_next = sts.b_zero ? psev_pkg::S_PUSH : psev_pkg::S_DIV_WAIT;
      end
      psev_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = psev_pkg::S_PUSH;
        end
      end
      psev_pkg::S_END_POP: state_next = psev_pkg::S_END_OUT;
      psev_pkg::S_END_OUT: begin
        if (!sts.out_hold) begin
          state_next = psev_pkg::S_IDLE;
        end
      end
      default:             state_next = psev_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      psev_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        cmd.accept     = in_valid;
        cmd.load_digit = in_valid && sts.in_op == psev_pkg::OP_DIGIT;
      end
      psev_pkg::S_PUSH:     cmd.push = 1'b1;
      psev_pkg::S_POP_B:    cmd.pop = 1'b1;
      psev_pkg::S_POP_A: begin
        cmd.cap_b = 1'b1;
        cmd.pop   = 1'b1;
      end
      psev_pkg::S_CAP_A:    cmd.cap_a = 1'b1;
      psev_pkg::S_EXEC:     cmd.exec = 1'b1;
      psev_pkg::S_DIV_GO: begin
        cmd.div_zero  = sts.b_zero;
        cmd.div_start = !sts.b_zero;
      end
      psev_pkg::S_DIV_WAIT: cmd.div_take = sts.div_done;
      psev_pkg::S_END_POP:  cmd.pop = 1'b1;
      psev_pkg::S_END_OUT:  cmd.finish = !sts.out_hold;
      default:              cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator, joining the controller and the datapath.
//
// One symbol item is taken on the in channel (in_valid, in_ready, symbol) at a time.
// Digit symbols push their value, operator symbols pop two operands and push the result,
// and the end symbol pops the top and sends one result item on the out channel
// (out_valid, out_ready, value and the four error flags), then clears the stack and flags.
// Per item: a digit is loaded, then pushed; an add, subtract, multiply or unknown operator
// pops and captures the right operand, then the left, executes and pushes the result;
// a division by zero pushes zero, and a division waits for the divider, which produces one
// quotient bit per cycle. The end symbol pops the top, then registers it as the result item.
// The result is held in an output register, and the next items are taken while it waits.
// Should a second end symbol arrive while the first result still waits, the block holds
// until the receiver takes the first.
// Reset clears the stack count, the flags, the controller and out_valid; the stack memory
// needs no clearing because only entries below the count are ever read.
`default_nettype none
module postfix_stack_evaluator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      symbol,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [psev_pkg::DATA_WIDTH-1:0] value,
  output logic                                 underflow_seen,
  output logic                                 overflow_seen,
  output logic                                 div_zero_seen,
  output logic                                 bad_operator_seen
);

  psev_pkg::psev_cmd_t cmd;
  psev_pkg::psev_sts_t sts;

  psev_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psev_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .symbol            (symbol),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .value             (value),
    .underflow_seen    (underflow_seen),
    .overflow_seen     (overflow_seen),
    .div_zero_seen     (div_zero_seen),
    .bad_operator_seen (bad_operator_seen)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second item was accepted before the first was finished.");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.pop, cmd.exec, cmd.div_start, cmd.finish, cmd.div_take}))
    else $error("Conflicting datapath commands were issued together.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && !out_ready))
    else $error("A waiting result would have been overwritten.");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("A finished expression did not present its result.");

endmodule
`default_nettype wire
